### hw/rtl/cai_pkg.sv
// Shared types and constants for the cartesian admittance integrator.
// Holds payload structs, configuration codes and defaults, and the control
// structs between the sequencer and the shared multiply unit. No dependencies.
package cai_pkg;

  localparam int AXES           = 3;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FIELD_W        = 32;

  localparam int IM_W     = 25;
  localparam int GAIN_W   = 31;
  localparam int TS_W     = 25;
  localparam int CHUNK_W  = 32;
  localparam int FRAC_LO  = 16;
  localparam int FRAC_HI  = 24;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_INV_MASS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STIFFNESS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 2'd3;

  localparam logic [IM_W-1:0]   INV_MASS_RST  = 25'd838861;
  localparam logic [GAIN_W-1:0] DAMPING_RST   = 31'd13107200;
  localparam logic [GAIN_W-1:0] STIFFNESS_RST = 31'd32768000;
  localparam logic [TS_W-1:0]   TIME_STEP_RST = 25'd134218;

  localparam logic OP_INTEGRATE = 1'b0;
  localparam logic OP_LOAD      = 1'b1;

  typedef struct packed {
    logic                      opcode;
    logic signed [FIELD_W-1:0] force_x;
    logic signed [FIELD_W-1:0] force_y;
    logic signed [FIELD_W-1:0] force_z;
    logic signed [FIELD_W-1:0] ref_pos_x;
    logic signed [FIELD_W-1:0] ref_pos_y;
    logic signed [FIELD_W-1:0] ref_pos_z;
    logic signed [FIELD_W-1:0] ref_vel_x;
    logic signed [FIELD_W-1:0] ref_vel_y;
    logic signed [FIELD_W-1:0] ref_vel_z;
  } in_item_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] cmd_vel_x;
    logic signed [FIELD_W-1:0] cmd_vel_y;
    logic signed [FIELD_W-1:0] cmd_vel_z;
    logic signed [FIELD_W-1:0] pos_x;
    logic signed [FIELD_W-1:0] pos_y;
    logic signed [FIELD_W-1:0] pos_z;
    logic                      saturated;
  } out_item_t;

  typedef struct packed {
    logic [IM_W-1:0]   inverse_mass;
    logic [GAIN_W-1:0] damping_gain;
    logic [GAIN_W-1:0] stiffness_gain;
    logic [TS_W-1:0]   time_step;
  } cfg_t;

  // sequencer -> multiply unit
  typedef struct packed {
    logic start;
    logic frac24;   // 1: drop 24 fraction bits, 0: drop 16
  } mul_ctl_t;

  // multiply unit -> sequencer
  typedef struct packed {
    logic done;
    logic clip;
  } mul_sts_t;

endpackage

### hw/rtl/cartesian_admittance_integrator.sv
// Cartesian admittance integrator, top level.
// Depends on cai_pkg, cai_cfg_regs, cai_mulsat and cai_seq.
//
// One input transaction is one control tick of a three-axis mass-spring-damper
// admittance law with diagonal gains shared by all axes. For each axis the
// block forms the damping term (v - vr)*damping, the spring term
// (x - xr)*stiffness, net = F - damping - spring, acc = net*inverse_mass, then
// v += acc*dt and x += v*dt with the new v. Every product is rounded half away
// from zero and saturated to DATA_WIDTH signed bits, every sum saturates too,
// and any clip raises saturated on that tick's result. Opcode OP_LOAD instead
// copies the reference position into the position state (saturated) and clears
// the velocity. Each tick yields exactly one result: the updated velocity
// (twist command) and position of each axis, low 32 bits of the state.
// All products go through one 32x31 multiplier that takes the operand
// magnitude 32 bits per cycle, in NCHUNK chunks, with NCHUNK =
// ceil((max(DATA_WIDTH,32)+1)/32), which is 2 for DATA_WIDTH up to 63.
// in_stall stays high while a tick is being worked. The result sits in an
// output register, so the next transaction can be taken while the previous
// result waits on out_stall; a tick only stalls at its end if that register
// is still occupied. Configuration writes are taken every cycle (cfg_ready is
// always high) and must only be issued while no tick is in progress.
// Velocity and position reset to zero.
module cartesian_admittance_integrator #(
  parameter int DATA_WIDTH = cai_pkg::DATA_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  cai_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output cai_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cai_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cai_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cai_pkg::*;

  localparam int EW = ((DATA_WIDTH > FIELD_W) ? DATA_WIDTH : FIELD_W) + 1;

  cfg_t                        cfg;
  logic                        accept;
  logic                        out_free;
  logic                        busy;
  logic                        fin;
  logic                        flag;
  logic signed [DATA_WIDTH-1:0] vel [AXES];
  logic signed [DATA_WIDTH-1:0] pos [AXES];
  mul_ctl_t                    mctl;
  mul_sts_t                    msts;
  logic signed [EW-1:0]        operand;
  logic [GAIN_W-1:0]           gain;
  logic signed [DATA_WIDTH-1:0] result;

  // a new tick is taken whenever the sequencer is idle
  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;
  // output register may be refilled when empty or being drained this cycle
  assign out_free = !out_valid || !out_stall;

  cai_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cai_seq #(
    .DW (DATA_WIDTH)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (in_data),
    .cfg      (cfg),
    .out_free (out_free),
    .busy     (busy),
    .fin      (fin),
    .vel      (vel),
    .pos      (pos),
    .flag     (flag),
    .mctl     (mctl),
    .operand  (operand),
    .gain     (gain),
    .result   (result),
    .msts     (msts)
  );

  // the one shared multiply / round / saturate unit
  cai_mulsat #(
    .DW (DATA_WIDTH)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mctl),
    .operand (operand),
    .gain    (gain),
    .result  (result),
    .sts     (msts)
  );

  // output register: valid is control, payload loads only on a finished tick
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // wide state is cut to its low 32 bits, narrow state is sign extended
  always_ff @(posedge clk) begin
    if (fin) begin
      out_data.cmd_vel_x <= FIELD_W'(vel[0]);
      out_data.cmd_vel_y <= FIELD_W'(vel[1]);
      out_data.cmd_vel_z <= FIELD_W'(vel[2]);
      out_data.pos_x     <= FIELD_W'(pos[0]);
      out_data.pos_y     <= FIELD_W'(pos[1]);
      out_data.pos_z     <= FIELD_W'(pos[2]);
      out_data.saturated <= flag;
    end
  end

  a_fin_free: assert property (@(posedge clk) disable iff (rst)
    fin |-> out_free)
    else $error("result would overwrite an undelivered transaction");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("block not busy after taking a transaction");

endmodule

### hw/rtl/cai_cfg_regs.sv
// Configuration register file for the admittance integrator.
// Depends on cai_pkg (register codes, widths, reset values).
module cai_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cai_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cai_pkg::CFG_DATA_W-1:0]  cfg_data,
  output cai_pkg::cfg_t                   cfg
);
  import cai_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inverse_mass   <= INV_MASS_RST;
      cfg.damping_gain   <= DAMPING_RST;
      cfg.stiffness_gain <= STIFFNESS_RST;
      cfg.time_step      <= TIME_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_INV_MASS:  cfg.inverse_mass   <= cfg_data[IM_W-1:0];
        CFG_DAMPING:   cfg.damping_gain   <= cfg_data[GAIN_W-1:0];
        CFG_STIFFNESS: cfg.stiffness_gain <= cfg_data[GAIN_W-1:0];
        CFG_TIME_STEP: cfg.time_step      <= cfg_data[TS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/cai_mulsat.sv
// Shared multiply unit: |operand| * gain over 32-bit chunks, one per cycle,
// then round half away from zero, drop 16 or 24 fraction bits, saturate.
// Depends on cai_pkg (widths, control structs).
module cai_mulsat #(
  parameter int DW = cai_pkg::DATA_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cai_pkg::mul_ctl_t          ctl,
  input  logic signed [((DW > cai_pkg::FIELD_W) ? DW : cai_pkg::FIELD_W):0] operand,
  input  logic [cai_pkg::GAIN_W-1:0] gain,
  output logic signed [DW-1:0]       result,
  output cai_pkg::mul_sts_t          sts
);
  import cai_pkg::*;

  localparam int EW     = ((DW > FIELD_W) ? DW : FIELD_W) + 1;
  localparam int NCHUNK = (EW + CHUNK_W - 1) / CHUNK_W;
  localparam int PAD_W  = NCHUNK * CHUNK_W;
  localparam int ACC_W  = PAD_W + GAIN_W;
  localparam int PROD_W = CHUNK_W + GAIN_W;
  localparam int CNT_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

  localparam logic [1:0] U_IDLE = 2'd0;
  localparam logic [1:0] U_MUL  = 2'd1;
  localparam logic [1:0] U_RND  = 2'd2;

  localparam logic [ACC_W-1:0]  LIM_POS = ACC_W'({(DW-1){1'b1}});
  localparam logic [ACC_W-1:0]  LIM_NEG = LIM_POS + ACC_W'(1);
  localparam logic [ACC_W-1:0]  HALF_LO = ACC_W'(1) << (FRAC_LO - 1);
  localparam logic [ACC_W-1:0]  HALF_HI = ACC_W'(1) << (FRAC_HI - 1);
  localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};

  logic [1:0]        ustate;
  logic              neg;
  logic              frac24;
  logic [PAD_W-1:0]  mag;
  logic [GAIN_W-1:0] gain_q;
  logic [ACC_W-1:0]  acc;
  logic [CNT_W-1:0]  chunk;

  logic [EW-1:0]       abs_op;
  logic [CHUNK_W-1:0]  chunk_val;
  logic [PROD_W-1:0]   prod;
  logic [ACC_W-1:0]    rnd;
  logic [ACC_W-1:0]    shifted;
  logic                over;
  logic [DW-1:0]       mag_dw;

  assign abs_op    = operand[EW-1] ? EW'(-operand) : EW'(operand);
  assign chunk_val = mag[chunk*CHUNK_W +: CHUNK_W];
  assign prod      = PROD_W'(chunk_val) * PROD_W'(gain_q);
  assign rnd       = acc + (frac24 ? HALF_HI : HALF_LO);
  assign shifted   = frac24 ? (rnd >> FRAC_HI) : (rnd >> FRAC_LO);
  assign over      = shifted > (neg ? LIM_NEG : LIM_POS);
  assign mag_dw    = shifted[DW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ustate   <= U_IDLE;
      sts.done <= 1'b0;
      sts.clip <= 1'b0;
    end else begin
      sts.done <= 1'b0;
      unique case (ustate)
        U_IDLE: begin
          if (ctl.start) begin
            ustate <= U_MUL;
          end
        end
        U_MUL: begin
          if (chunk == '0) begin
            ustate <= U_RND;
          end
        end
        U_RND: begin
          ustate   <= U_IDLE;
          sts.done <= 1'b1;
          sts.clip <= over;
        end
        default: ustate <= U_IDLE;
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (ustate == U_IDLE && ctl.start) begin
      neg    <= operand[EW-1];
      mag    <= PAD_W'(abs_op);
      gain_q <= gain;
      frac24 <= ctl.frac24;
      acc    <= '0;
      chunk  <= CNT_W'(NCHUNK - 1);
    end else if (ustate == U_MUL) begin
      // most significant chunk first
      acc   <= (acc << CHUNK_W) + ACC_W'(prod);
      chunk <= chunk - CNT_W'(1);
    end else if (ustate == U_RND) begin
      if (over) begin
        result <= neg ? VMIN : VMAX;
      end else begin
        result <= neg ? -$signed(mag_dw) : $signed(mag_dw);
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.start |-> ustate == U_IDLE)
    else $error("multiply started while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    sts.done |=> !sts.done)
    else $error("done held longer than one cycle");

endmodule

### hw/rtl/cai_seq.sv
// Tick sequencer: walks the axes and the five products per axis through the
// shared multiply unit (or applies a load), does the saturating sums and holds velocity/position.
// Depends on cai_pkg (payload, config and control structs).
module cai_seq #(
  parameter int DW = cai_pkg::DATA_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  cai_pkg::in_item_t          item,
  input  cai_pkg::cfg_t              cfg,
  input  logic                       out_free,
  output logic                       busy,
  output logic                       fin,
  output logic signed [DW-1:0]       vel [cai_pkg::AXES],
  output logic signed [DW-1:0]       pos [cai_pkg::AXES],
  output logic                       flag,
  output cai_pkg::mul_ctl_t          mctl,
  output logic signed [((DW > cai_pkg::FIELD_W) ? DW : cai_pkg::FIELD_W):0] operand,
  output logic [cai_pkg::GAIN_W-1:0] gain,
  input  logic signed [DW-1:0]       result,
  input  cai_pkg::mul_sts_t          msts
);
  import cai_pkg::*;

  localparam int EW   = ((DW > FIELD_W) ? DW : FIELD_W) + 1;
  localparam int SW   = EW + 1;
  localparam int AX_W = (AXES > 1) ? $clog2(AXES) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_PREP = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  // product being formed for the current axis
  localparam logic [2:0] MOP_DAMP   = 3'd0;
  localparam logic [2:0] MOP_SPRING = 3'd1;
  localparam logic [2:0] MOP_MASS   = 3'd2;
  localparam logic [2:0] MOP_DV     = 3'd3;
  localparam logic [2:0] MOP_DX     = 3'd4;

  function automatic logic [DW:0] sat_dw(input logic signed [SW-1:0] a);
    logic signed [SW-1:0] smax;
    logic signed [SW-1:0] smin;
    smax = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    smin = ~smax;
    if (a > smax) return {1'b1, smax[DW-1:0]};
    if (a < smin) return {1'b1, smin[DW-1:0]};
    return {1'b0, a[DW-1:0]};
  endfunction

  logic [2:0]         state;
  logic [2:0]         op;
  logic [AX_W-1:0]    axis;
  in_item_t           item_q;
  logic signed [DW-1:0] damp;
  logic signed [DW-1:0] spring;
  logic signed [DW-1:0] net;
  logic signed [DW-1:0] accel;

  logic signed [FIELD_W-1:0] f_arr  [AXES];
  logic signed [FIELD_W-1:0] xr_arr [AXES];
  logic signed [FIELD_W-1:0] vr_arr [AXES];
  logic signed [DW-1:0]      vel_cur;
  logic signed [DW-1:0]      pos_cur;
  logic [DW:0]               net_sat;
  logic [DW:0]               vel_sat;
  logic [DW:0]               pos_sat;
  logic [DW:0]               load_sat [AXES];
  logic                      load_clip;

  assign f_arr[0]  = item_q.force_x;
  assign f_arr[1]  = item_q.force_y;
  assign f_arr[2]  = item_q.force_z;
  assign xr_arr[0] = item_q.ref_pos_x;
  assign xr_arr[1] = item_q.ref_pos_y;
  assign xr_arr[2] = item_q.ref_pos_z;
  assign vr_arr[0] = item_q.ref_vel_x;
  assign vr_arr[1] = item_q.ref_vel_y;
  assign vr_arr[2] = item_q.ref_vel_z;

  assign vel_cur = vel[axis];
  assign pos_cur = pos[axis];

  assign net_sat = sat_dw(SW'(f_arr[axis]) - SW'(damp) - SW'(spring));
  assign vel_sat = sat_dw(SW'(vel_cur) + SW'(result));
  assign pos_sat = sat_dw(SW'(pos_cur) + SW'(result));

  always_comb begin
    load_clip = 1'b0;
    for (int i = 0; i < AXES; i++) begin
      load_sat[i] = sat_dw(SW'(xr_arr[i]));
      load_clip   = load_clip | load_sat[i][DW];
    end
  end

  // operand, gain and scaling for the product in flight
  always_comb begin
    mctl.start  = (state == S_PREP);
    mctl.frac24 = 1'b1;
    operand     = EW'(vel_cur);
    gain        = GAIN_W'(cfg.time_step);
    unique case (op) inside
      MOP_DAMP: begin
        mctl.frac24 = 1'b0;
        operand     = EW'(vel_cur) - EW'(vr_arr[axis]);
        gain        = cfg.damping_gain;
      end
      MOP_SPRING: begin
        mctl.frac24 = 1'b0;
        operand     = EW'(pos_cur) - EW'(xr_arr[axis]);
        gain        = cfg.stiffness_gain;
      end
      MOP_MASS: begin
        operand = EW'(net);
        gain    = GAIN_W'(cfg.inverse_mass);
      end
      MOP_DV: begin
        operand = EW'(accel);
      end
      MOP_DX: begin
        operand = EW'(vel_cur);
      end
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign fin  = (state == S_FIN) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= MOP_DAMP;
      axis  <= '0;
      flag  <= 1'b0;
      for (int i = 0; i < AXES; i++) begin
        vel[i] <= '0;
        pos[i] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            axis <= '0;
            op   <= MOP_DAMP;
            flag <= 1'b0;
            state <= (item.opcode == OP_LOAD) ? S_LOAD : S_PREP;
          end
        end
        S_LOAD: begin
          for (int i = 0; i < AXES; i++) begin
            pos[i] <= load_sat[i][DW-1:0];
            vel[i] <= '0;
          end
          flag  <= load_clip;
          state <= S_FIN;
        end
        S_PREP: state <= S_WAIT;
        S_WAIT: begin
          if (msts.done) begin
            flag <= flag | msts.clip;
            unique case (op) inside
              MOP_DAMP: begin
                op    <= MOP_SPRING;
                state <= S_PREP;
              end
              MOP_MASS: begin
                op    <= MOP_DV;
                state <= S_PREP;
              end
              default: state <= S_ADD;
            endcase
          end
        end
        S_ADD: begin
          state <= S_PREP;
          unique case (op) inside
            MOP_SPRING: begin
              flag <= flag | net_sat[DW];
              op   <= MOP_MASS;
            end
            MOP_DV: begin
              vel[axis] <= vel_sat[DW-1:0];
              flag      <= flag | vel_sat[DW];
              op        <= MOP_DX;
            end
            default: begin
              pos[axis] <= pos_sat[DW-1:0];
              flag      <= flag | pos_sat[DW];
              op        <= MOP_DAMP;
              if (axis == AX_W'(AXES - 1)) begin
                state <= S_FIN;
              end else begin
                axis <= axis + AX_W'(1);
              end
            end
          endcase
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // item copy and product results, no reset needed
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      item_q <= item;
    end
    if (state == S_WAIT && msts.done) begin
      if (op == MOP_DAMP)   damp   <= result;
      if (op == MOP_SPRING) spring <= result;
      if (op == MOP_MASS)   accel  <= result;
    end
    if (state == S_ADD && op == MOP_SPRING) begin
      net <= net_sat[DW-1:0];
    end
  end

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    accept |-> state == S_IDLE)
    else $error("transaction taken while a tick is in progress");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    msts.done |-> state == S_WAIT)
    else $error("product finished with no one waiting for it");

endmodule
